// ===== src/fm_register_write_attenuator_macros.svh =====
// assertion helpers for the checker file
`ifndef FM_REGISTER_WRITE_ATTENUATOR_MACROS_SVH
`define FM_REGISTER_WRITE_ATTENUATOR_MACROS_SVH

// same-cycle implication, ignored while reset is asserted
`define FMRWA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while reset is asserted
`define FMRWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define FMRWA_ASSERT_RST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fmrwa_pkg.sv =====
package fmrwa_pkg;

  // action codes carried in the input tuser
  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_ATTEN   = 2'd1,
    ACT_QUIET   = 2'd2,
    ACT_SILENCE = 2'd3
  } action_t;

  // register map constants
  localparam logic [7:0] ADDR_LEVEL_LO = 8'h40;
  localparam logic [7:0] ADDR_LEVEL_HI = 8'h55;
  localparam logic [7:0] ADDR_CARRIER  = 8'h43;
  localparam logic [7:0] ADDR_KEY_LO   = 8'hb0;
  localparam logic [7:0] ADDR_KEY_HI   = 8'hb8;
  localparam logic [7:0] ADDR_CONN_LO  = 8'hc0;
  localparam logic [7:0] ADDR_CONN_HI  = 8'hc8;
  localparam logic [7:0] ADDR_RELEASE  = 8'h80;
  localparam logic [7:0] ADDR_RHYTHM   = 8'hbd;
  localparam logic [7:0] KEY_ON_MASK   = 8'hdf;
  localparam logic [7:0] RELEASE_FAST  = 8'hff;
  localparam logic [5:0] ATT_MAX       = 6'd63;
  localparam logic [7:0] LEVEL_MAX     = 8'd63;

  localparam int         NUM_CH        = 9;
  localparam int         NUM_LEVELS    = 22;
  localparam logic [3:0] LAST_CH       = 4'(NUM_CH - 1);

  // command queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // classified command passed from front to back
  typedef struct packed {
    action_t    kind;
    logic [7:0] addr;
    logic [7:0] value;
    logic [5:0] att;
    logic       quiet;
    logic       key_reg;
    logic       lvl_reg;
    logic       conn_reg;
    logic       car_hit;
    logic       mod_hit;
    logic [3:0] mod_ch;
  } cmd_t;

  // operator offset of a channel
  function automatic logic [7:0] opofs(input logic [3:0] ch);
    logic [7:0] o;
    case (ch)
      4'd0:    o = 8'h00;
      4'd1:    o = 8'h01;
      4'd2:    o = 8'h02;
      4'd3:    o = 8'h08;
      4'd4:    o = 8'h09;
      4'd5:    o = 8'h0a;
      4'd6:    o = 8'h10;
      4'd7:    o = 8'h11;
      4'd8:    o = 8'h12;
      default: o = 8'h00;
    endcase
    return o;
  endfunction

  // add attenuation to a level byte, saturating at the maximum level
  function automatic logic [7:0] attenuate(input logic [7:0] v, input logic [5:0] a);
    logic [6:0] s;
    s = {1'b0, v[5:0]} + {1'b0, a};
    if (s[6]) return LEVEL_MAX;
    return {v[7:6], s[5:0]};
  endfunction

endpackage

// ===== src/fmrwa_queue.sv =====
module fmrwa_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fmrwa_pkg::cmd_t    push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output fmrwa_pkg::cmd_t    pop_data
);
  import fmrwa_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full     = (count_r == Q_CW'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/fmrwa_front.sv =====
module fmrwa_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [23:0]        in_tdata,   // reg_address, reg_value, attenuation, quiet, pad
  input  logic [1:0]         in_tuser,   // action
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               q_full,
  output logic               push,
  output fmrwa_pkg::cmd_t    push_data
);
  import fmrwa_pkg::*;

  logic    writes_disabled_r;
  action_t act;
  cmd_t    cmd;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      writes_disabled_r <= 1'b0;
    end else if (cfg_wr_en) begin
      writes_disabled_r <= cfg_wr_data;
    end
  end

  assign act       = action_t'(in_tuser);
  assign in_tready = !q_full;

  // classify the incoming transaction
  always_comb begin
    cmd          = '0;
    cmd.kind     = act;
    cmd.addr     = in_tdata[7:0];
    cmd.value    = in_tdata[15:8];
    cmd.att      = in_tdata[21:16];
    cmd.quiet    = in_tdata[22];
    cmd.key_reg  = (cmd.addr >= ADDR_KEY_LO) && (cmd.addr <= ADDR_KEY_HI);
    cmd.lvl_reg  = (cmd.addr >= ADDR_LEVEL_LO) && (cmd.addr <= ADDR_LEVEL_HI);
    cmd.conn_reg = (cmd.addr >= ADDR_CONN_LO) && (cmd.addr <= ADDR_CONN_HI);
    for (int i = 0; i < NUM_CH; i++) begin
      if (cmd.addr == ADDR_CARRIER + opofs(4'(i))) begin
        cmd.car_hit = 1'b1;
      end
      if (cmd.addr == ADDR_LEVEL_LO + opofs(4'(i))) begin
        cmd.mod_hit = 1'b1;
        cmd.mod_ch  = 4'(i);
      end
    end
  end

  // disabled plain writes are taken and dropped
  assign push      = in_tvalid && in_tready && !(act == ACT_WRITE && writes_disabled_r);
  assign push_data = cmd;

endmodule

// ===== src/fmrwa_back.sv =====
module fmrwa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  fmrwa_pkg::cmd_t    q_data,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // out_address, out_value
  output logic               out_tlast   // last
);
  import fmrwa_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;
  typedef enum logic [1:0] {PH_A, PH_B, PH_TAIL} phase_t;

  state_t     state_r, state_nxt;
  phase_t     ph_r, ph_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [3:0] ch_r, ch_nxt;
  logic [5:0] cur_att_r, cur_att_nxt;
  logic [5:0] saved_att_r, saved_att_nxt;
  logic       quiet_r, quiet_nxt;
  logic [7:0] level_r [NUM_LEVELS];
  logic [NUM_CH-1:0] conn_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_addr_r, out_addr_nxt;
  logic [7:0] out_val_r, out_val_nxt;
  logic       out_last_r, out_last_nxt;

  logic       slot_free;
  logic       lvl_we, conn_we;
  logic [7:0] wr_val, o;
  logic [4:0] lvl_idx, rd_idx;
  logic [3:0] conn_idx;
  logic       att_hit;
  logic       e_last;

  assign slot_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r, out_addr_r};
  assign out_tlast  = out_last_r;

  // plain write datapath
  assign wr_val   = (quiet_r && cmd_r.key_reg) ? (cmd_r.value & KEY_ON_MASK) : cmd_r.value;
  assign lvl_idx  = 5'(cmd_r.addr - ADDR_LEVEL_LO);
  assign conn_idx = cmd_r.addr[3:0];
  assign att_hit  = cmd_r.car_hit || (cmd_r.mod_hit && conn_r[cmd_r.mod_ch]);
  assign o        = opofs(ch_r);
  assign rd_idx   = (ph_r == PH_A) ? 5'(o + 8'd3) : o[4:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    cur_att_nxt   = cur_att_r;
    saved_att_nxt = saved_att_r;
    quiet_nxt     = quiet_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    lvl_we        = 1'b0;
    conn_we       = 1'b0;
    e_last        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          ch_nxt    = '0;
          ph_nxt    = PH_A;
          state_nxt = S_RUN;
          case (q_data.kind)
            ACT_ATTEN: cur_att_nxt = q_data.att;
            ACT_QUIET: begin
              quiet_nxt = q_data.quiet;
              if (q_data.quiet) begin
                saved_att_nxt = cur_att_r;
                cur_att_nxt   = ATT_MAX;
              end else begin
                cur_att_nxt = saved_att_r;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          case (cmd_r.kind)
            ACT_WRITE: begin
              out_addr_nxt = cmd_r.addr;
              out_val_nxt  = att_hit ? attenuate(wr_val, cur_att_r) : wr_val;
              e_last       = 1'b1;
              lvl_we       = cmd_r.lvl_reg;
              conn_we      = cmd_r.conn_reg;
            end
            ACT_SILENCE: begin
              unique case (ph_r)
                PH_A: begin
                  out_addr_nxt = ADDR_KEY_LO + {4'd0, ch_r};
                  out_val_nxt  = 8'h00;
                  ph_nxt       = PH_B;
                end
                PH_B: begin
                  out_addr_nxt = ADDR_RELEASE + o;
                  out_val_nxt  = RELEASE_FAST;
                  if (ch_r == LAST_CH) begin
                    ph_nxt = PH_TAIL;
                  end else begin
                    ch_nxt = ch_r + 1'b1;
                    ph_nxt = PH_A;
                  end
                end
                default: begin
                  out_addr_nxt = ADDR_RHYTHM;
                  out_val_nxt  = 8'h00;
                  e_last       = 1'b1;
                end
              endcase
            end
            default: begin
              // level replay: carrier, then modulator when connected
              out_val_nxt = attenuate(level_r[rd_idx], cur_att_r);
              if (ph_r == PH_A) begin
                out_addr_nxt = ADDR_CARRIER + o;
                if (conn_r[ch_r]) begin
                  ph_nxt = PH_B;
                end else if (ch_r == LAST_CH) begin
                  e_last = 1'b1;
                end else begin
                  ch_nxt = ch_r + 1'b1;
                end
              end else begin
                out_addr_nxt = ADDR_LEVEL_LO + o;
                if (ch_r == LAST_CH) begin
                  e_last = 1'b1;
                end else begin
                  ch_nxt = ch_r + 1'b1;
                  ph_nxt = PH_A;
                end
              end
            end
          endcase
          out_last_nxt = e_last;
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_A;
      ch_r        <= '0;
      cur_att_r   <= '0;
      saved_att_r <= '0;
      quiet_r     <= 1'b0;
      out_valid_r <= 1'b0;
      conn_r      <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      ch_r        <= ch_nxt;
      cur_att_r   <= cur_att_nxt;
      saved_att_r <= saved_att_nxt;
      quiet_r     <= quiet_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
      out_addr_r  <= out_addr_nxt;
      out_val_r   <= out_val_nxt;
      out_last_r  <= out_last_nxt;
      if (lvl_we) begin
        level_r[lvl_idx] <= wr_val;
      end
      if (conn_we) begin
        conn_r[conn_idx] <= wr_val[0];
      end
    end
  end

endmodule

// ===== src/fm_register_write_attenuator.sv =====
// Register-write rewriter for a 9-channel FM synthesizer port.
// in_*: one transaction per action; tuser holds the action code, tdata the
//   register address, data byte, attenuation and quiet flag. Plain register
//   writes are dropped without output while cfg_wr_data was last written 1.
// out_*: the synthesizer register writes caused by each action, in order;
//   tlast marks the final write of an action.
// An accepted action is queued, then popped into the back-end command register;
//   each write is registered on out_*. Per action the back end emits one write
//   for a plain write, one per carrier and per connected modulator for a level
//   replay, and a key-off and fast release per channel, then the rhythm write,
//   for silence all, one write per cycle while out_tready does not stall it.
// A two-entry command queue lets new actions be accepted while the back end
//   is busy; in_tready drops only when it is full.
// Reset (synchronous, rst_n low) clears the level and connection caches,
//   the attenuation, quiet mode, the disable bit and the queue.
// When out_tready is low the pending write holds on out_* and the back end
//   stalls; the front keeps filling the queue until it is full.
module fm_register_write_attenuator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // reg_address, reg_value, attenuation, quiet, pad
  input  logic [1:0]  in_tuser,    // action
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data, // writes_disabled
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // out_address, out_value
  output logic        out_tlast    // last
);
  import fmrwa_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_wdata, q_rdata;

  // accept and classify
  fmrwa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (q_push),
    .push_data   (q_wdata)
  );

  // command queue between front and back
  fmrwa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  // execute and emit register writes
  fmrwa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/fmrwa_checker.sv =====
`include "fm_register_write_attenuator_macros.svh"

module fmrwa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);
  import fmrwa_pkg::*;

  // stalled output transaction holds
  `FMRWA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")

  // reset empties the output and opens the input
  `FMRWA_ASSERT_RST(a_reset_clear, clk, !rst_n, !out_tvalid && in_tready, "state not cleared by reset")

  // writes of one action leave back to back
  `FMRWA_ASSERT_NEXT(a_run_contig, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid, "gap inside a run of writes")

  // the rhythm register write always ends its action
  `FMRWA_ASSERT_NOW(a_rhythm_last, clk, rst_n, out_tvalid && (out_tdata[7:0] == ADDR_RHYTHM), out_tlast, "rhythm write not marked last")

endmodule

bind fm_register_write_attenuator fmrwa_checker u_fmrwa_checker (.*);

// ===== tb/fm_register_write_attenuator_tb.sv =====
`timescale 1ns / 100ps

module fm_register_write_attenuator_tb;
  import fmrwa_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int NUM_DIR_ROWS = 25;

  // one synthesizer register write as seen on the result channel
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] value;
    logic       last;
  } fm_write_t;

  // directed stimulus row, ref_value typed in where chk is set
  typedef struct packed {
    action_t    act;
    logic [7:0] addr;
    logic [7:0] val;
    logic [5:0] att;
    logic       q;
    logic       chk;
    logic [7:0] ref_value;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // reg_address, reg_value, attenuation, quiet, pad
  logic [1:0]  in_tuser;    // action
  logic        cfg_wr_en;
  logic        cfg_wr_data; // writes_disabled
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // out_address, out_value
  logic        out_tlast;   // last

  // typed-in expectation traveling with the offered transaction
  logic        drv_ref_on;
  logic [7:0]  drv_ref_value;

  // predictor state
  logic [7:0]  lvl_mem [NUM_LEVELS];
  logic        conn_mem [NUM_CH];
  logic [5:0]  atten_now;
  logic [5:0]  atten_saved;
  logic        quiet_on;
  logic        wr_off;

  fm_write_t   synth_writes_due [$];
  fm_write_t   got_write;
  fm_write_t   want_write;
  dir_row_t    dir_rows [NUM_DIR_ROWS];

  int          fail_count = 0;
  int          stall_cycles = 0;
  int          tx_burst_left = 0;
  int          rx_burst_left = 0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;

  fm_register_write_attenuator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // level plus attenuation, pinned at the maximum level when the low six bits overflow
  function automatic logic [7:0] level_sum(input logic [7:0] v, input logic [5:0] a);
    int total;
    total = int'(v[5:0]) + int'(a);
    if (total > 63) return LEVEL_MAX;
    return v + 8'(a);
  endfunction

  function automatic logic [7:0] chan_ofs(input int ch);
    return 8'((ch / 3) * 8 + ch % 3);
  endfunction

  function automatic void push_write(input logic [7:0] addr, input logic [7:0] value);
    synth_writes_due.push_back(fm_write_t'{addr, value, 1'b0});
  endfunction

  // carriers of all channels, modulators of connected ones, at attenuation a
  function automatic void replay_levels(input logic [5:0] a);
    int ch;
    logic [7:0] ofs;
    atten_now = a;
    for (ch = 0; ch < NUM_CH; ch++) begin
      ofs = chan_ofs(ch);
      push_write(ADDR_CARRIER + ofs, level_sum(lvl_mem[ofs + 8'd3], a));
      if (conn_mem[ch]) push_write(ADDR_LEVEL_LO + ofs, level_sum(lvl_mem[ofs], a));
    end
  endfunction

  // expected synthesizer writes for one accepted action
  function automatic void predict_rewrite(input action_t act, input logic [7:0] addr,
                                          input logic [7:0] val, input logic [5:0] att,
                                          input logic q);
    int mark;
    int ch;
    logic [7:0] v;
    logic [7:0] ofs;
    mark = synth_writes_due.size();
    case (act)
      ACT_WRITE: begin
        if (!wr_off) begin
          v = val;
          if (quiet_on && addr >= ADDR_KEY_LO && addr <= ADDR_KEY_HI) v = v & KEY_ON_MASK;
          if (addr >= ADDR_LEVEL_LO && addr <= ADDR_LEVEL_HI) lvl_mem[addr - ADDR_LEVEL_LO] = v;
          if (addr >= ADDR_CONN_LO && addr <= ADDR_CONN_HI) conn_mem[addr - ADDR_CONN_LO] = v[0];
          if (atten_now != 6'd0) begin
            for (ch = 0; ch < NUM_CH; ch++) begin
              ofs = chan_ofs(ch);
              if (addr == ADDR_CARRIER + ofs)
                v = level_sum(v, atten_now);
              else if (addr == ADDR_LEVEL_LO + ofs && conn_mem[ch])
                v = level_sum(v, atten_now);
            end
          end
          push_write(addr, v);
        end
      end
      ACT_ATTEN: replay_levels(att);
      ACT_QUIET: begin
        quiet_on = q;
        if (q) begin
          atten_saved = atten_now;
          replay_levels(ATT_MAX);
        end else begin
          replay_levels(atten_saved);
        end
      end
      default: begin
        for (ch = 0; ch < NUM_CH; ch++) begin
          push_write(ADDR_KEY_LO + 8'(ch), 8'h00);
          push_write(ADDR_RELEASE + chan_ofs(ch), RELEASE_FAST);
        end
        push_write(ADDR_RHYTHM, 8'h00);
      end
    endcase
    if (synth_writes_due.size() > mark)
      synth_writes_due[synth_writes_due.size() - 1].last = 1'b1;
  endfunction

  // checker and predictor, both sampling at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) wr_off = cfg_wr_data;
      // result transaction
      if (out_tvalid && out_tready) begin
        got_write = fm_write_t'{out_tdata[7:0], out_tdata[15:8], out_tlast};
        if (synth_writes_due.size() == 0) begin
          $error("unexpected write: out_address %h out_value %h last %b",
                 got_write.addr, got_write.value, got_write.last);
          fail_count++;
        end else begin
          want_write = synth_writes_due.pop_front();
          if (got_write.addr !== want_write.addr) begin
            $error("out_address: expected %h, got %h", want_write.addr, got_write.addr);
            fail_count++;
          end
          if (got_write.value !== want_write.value) begin
            $error("out_value: expected %h, got %h", want_write.value, got_write.value);
            fail_count++;
          end
          if (got_write.last !== want_write.last) begin
            $error("last: expected %b, got %b", want_write.last, got_write.last);
            fail_count++;
          end
        end
      end
      // input transaction
      if (in_tvalid && in_tready) begin
        predict_rewrite(action_t'(in_tuser), in_tdata[7:0], in_tdata[15:8],
                        in_tdata[21:16], in_tdata[22]);
        if (drv_ref_on) begin
          void'(synth_writes_due.pop_back());
          synth_writes_due.push_back(fm_write_t'{in_tdata[7:0], drv_ref_value, 1'b1});
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random hold-off per write, bursts without, one long squeeze
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        gap = SQUEEZE_CYCLES;
        squeeze_done = 1'b1;
      end else if (rx_burst_left > 0) begin
        gap = 0;
        rx_burst_left--;
      end else begin
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) rx_burst_left = $urandom_range(5, 30);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff (out_tvalid && out_tready));
    end
  end

  // offer one action and wait for its transaction
  task automatic send_action(input action_t act, input logic [7:0] addr, input logic [7:0] val,
                             input logic [5:0] att, input logic q, input logic ref_on,
                             input logic [7:0] ref_value);
    int gap;
    if (tx_burst_left > 0) begin
      gap = 0;
      tx_burst_left--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0) tx_burst_left = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid     <= 1'b1;
    in_tuser      <= act;
    in_tdata      <= {1'b0, q, att, val, addr};
    drv_ref_on    <= ref_on;
    drv_ref_value <= ref_value;
    @(posedge clk iff in_tready);
  endtask

  // mostly register writes aimed at the interesting address ranges
  task automatic send_random(input int count);
    int pick;
    int n;
    action_t act;
    logic [7:0] addr;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       addr = ADDR_LEVEL_LO + 8'($urandom_range(0, NUM_LEVELS - 1));
        1:       addr = ADDR_CONN_LO + 8'($urandom_range(0, NUM_CH - 1));
        2:       addr = ADDR_KEY_LO + 8'($urandom_range(0, NUM_CH - 1));
        default: addr = 8'($urandom_range(0, 255));
      endcase
      if (pick < 72)      act = ACT_WRITE;
      else if (pick < 84) act = ACT_ATTEN;
      else if (pick < 94) act = ACT_QUIET;
      else                act = ACT_SILENCE;
      send_action(act, addr, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)), 1'b0, 8'h00);
    end
  endtask

  // wait until every expected write has come, then settle further for dropped writes
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (synth_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic disabled);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= disabled;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // main sequence
  initial begin
    int i;
    dir_row_t row;
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= ACT_WRITE;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 1'b0;
    drv_ref_on    <= 1'b0;
    drv_ref_value <= 8'h00;
    for (i = 0; i < NUM_LEVELS; i++) lvl_mem[i] = 8'h00;
    for (i = 0; i < NUM_CH; i++) conn_mem[i] = 1'b0;
    atten_now   = 6'd0;
    atten_saved = 6'd0;
    quiet_on    = 1'b0;
    wr_off      = 1'b0;

    dir_rows = '{
      // zero attenuation: writes pass unchanged, caches get filled
      '{ACT_WRITE,   8'h43, 8'h2a, 6'd0,  1'b0, 1'b1, 8'h2a},
      '{ACT_WRITE,   8'h40, 8'hc5, 6'd0,  1'b0, 1'b1, 8'hc5},
      '{ACT_WRITE,   8'hc0, 8'h01, 6'd0,  1'b0, 1'b1, 8'h01},
      '{ACT_WRITE,   8'h55, 8'hff, 6'd0,  1'b0, 1'b1, 8'hff},
      '{ACT_WRITE,   8'hc8, 8'hff, 6'd0,  1'b0, 1'b1, 8'hff},
      '{ACT_WRITE,   8'h4b, 8'h3f, 6'd0,  1'b0, 1'b1, 8'h3f},
      // full attenuation: sums at the limit and past it
      '{ACT_ATTEN,   8'h00, 8'h00, 6'd63, 1'b0, 1'b0, 8'h00},
      '{ACT_WRITE,   8'h43, 8'h00, 6'd0,  1'b0, 1'b1, 8'h3f},
      '{ACT_WRITE,   8'h43, 8'hc1, 6'd0,  1'b0, 1'b1, 8'h3f},
      '{ACT_WRITE,   8'h40, 8'h80, 6'd0,  1'b0, 1'b1, 8'hbf},
      '{ACT_WRITE,   8'h41, 8'h10, 6'd0,  1'b0, 1'b1, 8'h10},
      '{ACT_WRITE,   8'h00, 8'h00, 6'd0,  1'b0, 1'b1, 8'h00},
      '{ACT_WRITE,   8'hff, 8'hff, 6'd0,  1'b0, 1'b1, 8'hff},
      '{ACT_ATTEN,   8'h00, 8'h00, 6'd1,  1'b0, 1'b0, 8'h00},
      // quiet mode: key-on masked inside the key range only
      '{ACT_QUIET,   8'h00, 8'h00, 6'd0,  1'b1, 1'b0, 8'h00},
      '{ACT_WRITE,   8'hb0, 8'hff, 6'd0,  1'b0, 1'b1, 8'hdf},
      '{ACT_WRITE,   8'hb8, 8'h20, 6'd0,  1'b0, 1'b1, 8'h00},
      '{ACT_WRITE,   8'hb9, 8'h20, 6'd0,  1'b0, 1'b1, 8'h20},
      '{ACT_WRITE,   8'haf, 8'h3f, 6'd0,  1'b0, 1'b1, 8'h3f},
      // entering quiet twice loses the saved attenuation
      '{ACT_QUIET,   8'h00, 8'h00, 6'd0,  1'b1, 1'b0, 8'h00},
      '{ACT_QUIET,   8'h00, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00},
      '{ACT_WRITE,   8'hb4, 8'hff, 6'd0,  1'b0, 1'b1, 8'hff},
      '{ACT_ATTEN,   8'h00, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00},
      '{ACT_SILENCE, 8'h00, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00},
      '{ACT_WRITE,   8'h55, 8'h3f, 6'd0,  1'b0, 1'b1, 8'h3f}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    write_cfg(1'b0);
    for (i = 0; i < NUM_DIR_ROWS; i++) begin
      row = dir_rows[i];
      send_action(row.act, row.addr, row.val, row.att, row.q, row.chk, row.ref_value);
    end
    settle();

    // random phases across both register settings
    write_cfg(1'b1);
    send_random(20);
    settle();
    write_cfg(1'b0);
    squeeze_req = 1'b1;
    send_random(35);
    settle();
    write_cfg(1'b1);
    send_random(10);
    settle();
    write_cfg(1'b0);
    send_random(20);
    settle();

    if (synth_writes_due.size() != 0) begin
      $error("%0d expected writes never arrived", synth_writes_due.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
